// ===== hw/rtl/tdfc_pkg.sv =====
// shared types and constants of the tick duplicate filter
// no dependencies

package tdfc_pkg;

  localparam int unsigned FOLD_W  = 32;
  localparam int unsigned OCC_W   = 7;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned CNT_W   = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic [63:0]       symbol;
    logic [62:0]       time_ns;
    logic [FOLD_W-1:0] price_fold;
    logic [FOLD_W-1:0] volume_fold;
  } fp_t;

  localparam int unsigned FP_W = $bits(fp_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_LIMIT,
    ST_DONE
  } tdfc_state_e;

endpackage

// ===== hw/rtl/tdfc_if.sv =====
// valid/ready channels for input ticks and result items
// no dependencies

interface tdfc_tick_if;
  logic        valid;
  logic        ready;
  logic [63:0] tick_symbol;
  logic [62:0] tick_time_ns;
  logic [63:0] price_pattern;
  logic [63:0] trade_volume;

  modport source (output valid, tick_symbol, tick_time_ns, price_pattern, trade_volume,
                  input ready);
  modport sink   (input valid, tick_symbol, tick_time_ns, price_pattern, trade_volume,
                  output ready);
endinterface

interface tdfc_res_if;
  logic        valid;
  logic        ready;
  logic        was_duplicate;
  logic [63:0] processed_total;
  logic [63:0] duplicate_total;
  logic [6:0]  occupancy;

  modport source (output valid, was_duplicate, processed_total, duplicate_total, occupancy,
                  input ready);
  modport sink   (input valid, was_duplicate, processed_total, duplicate_total, occupancy,
                  output ready);
endinterface

// ===== hw/rtl/tdfc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module tdfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/tdfc_front.sv =====
// front end: accepts ticks, folds price and volume into a fingerprint
// and buffers it in a two-entry queue; uses tdfc_pkg and tdfc_tick_if

module tdfc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tdfc_tick_if.sink            tick_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output tdfc_pkg::fp_t        q_data_o
);

  import tdfc_pkg::*;

  function automatic logic [FOLD_W-1:0] fold64(input logic [63:0] v);
    return v[63:32] ^ v[31:0];
  endfunction

  fp_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  fp_t        fp;

  assign fp.symbol      = tick_i.tick_symbol;
  assign fp.time_ns     = tick_i.tick_time_ns;
  assign fp.price_fold  = fold64(tick_i.price_pattern);
  assign fp.volume_fold = fold64(tick_i.trade_volume);

  assign tick_i.ready = (cnt_q != 2'd2);
  assign push         = tick_i.valid && tick_i.ready;
  assign q_valid_o    = (cnt_q != 2'd0);
  assign pop          = q_valid_o && q_ready_i;
  assign q_data_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= fp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/tdfc_back.sv =====
// back end: scans the fingerprint ring, inserts on a miss, trims to the
// entry limit and drives the result register; uses tdfc_pkg, tdfc_ram, tdfc_res_if

module tdfc_back #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tdfc_pkg::LIMIT_W-1:0]  entry_limit_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  tdfc_pkg::fp_t                 q_data_i,
  tdfc_res_if.source                    res_o
);

  import tdfc_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int unsigned SW = AW + 2;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [FW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  tdfc_state_e     state_q, state_d;
  logic [AW-1:0]   oldest_q;
  logic [FW-1:0]   fill_q;
  logic [CNT_W-1:0] seen_q, dup_q;
  fp_t             fp_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [FW-1:0]   rd_cnt_q;
  logic            pend_q;
  logic            hit_q;
  logic            out_valid_q;
  logic            out_dup_q;
  logic [CNT_W-1:0] out_seen_q, out_dupcnt_q;
  logic [OCC_W-1:0] out_occ_q;

  logic            issue, match, miss, out_free, out_load;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [FP_W-1:0] ram_rdata;
  logic            full;
  logic [FW-1:0]   lim;
  logic [CW-1:0]   lim_w;

  assign lim_w = (CW'(entry_limit_i) < CW'(CAPACITY)) ? CW'(entry_limit_i) : CW'(CAPACITY);
  assign lim   = lim_w[FW-1:0];
  assign full  = (fill_q == FW'(CAPACITY));
  assign out_free = !out_valid_q || res_o.ready;

  tdfc_ram #(
    .WIDTH (FP_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (fp_q),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // control outputs
  always_comb begin
    q_ready_o = 1'b0;
    issue     = 1'b0;
    match     = 1'b0;
    miss      = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ram_waddr = full ? oldest_q : wrap_add(oldest_q, fill_q);
    case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
      end
      ST_SCAN: begin
        issue = (rd_cnt_q != fill_q);
        match = pend_q && (fp_t'(ram_rdata) == fp_q);
        miss  = !match && !issue;
      end
      ST_INSERT: begin
        ram_we = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_DONE;
        end else if (miss) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: state_d = ST_LIMIT;
      ST_LIMIT:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) begin
      fp_q <= q_data_i;
    end
    if (out_load) begin
      out_dup_q    <= hit_q;
      out_seen_q   <= seen_q + CNT_W'(1);
      out_dupcnt_q <= dup_q + CNT_W'(hit_q);
      out_occ_q    <= OCC_W'(fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      fill_q      <= '0;
      seen_q      <= '0;
      dup_q       <= '0;
      rd_ptr_q    <= '0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          rd_ptr_q <= oldest_q;
          rd_cnt_q <= '0;
          pend_q   <= 1'b0;
        end
        ST_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            rd_ptr_q <= wrap_inc(rd_ptr_q);
            rd_cnt_q <= rd_cnt_q + FW'(1);
          end
          if (match) begin
            hit_q <= 1'b1;
          end else if (miss) begin
            hit_q <= 1'b0;
          end
        end
        ST_INSERT: begin
          if (full) begin
            oldest_q <= wrap_inc(oldest_q);
          end else begin
            fill_q <= fill_q + FW'(1);
          end
        end
        ST_LIMIT: begin
          if (fill_q > lim) begin
            oldest_q <= wrap_add(oldest_q, fill_q - lim);
            fill_q   <= lim;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            seen_q <= seen_q + CNT_W'(1);
            dup_q  <= dup_q + CNT_W'(hit_q);
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.was_duplicate   = out_dup_q;
  assign res_o.processed_total = out_seen_q;
  assign res_o.duplicate_total = out_dupcnt_q;
  assign res_o.occupancy       = out_occ_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("ring occupancy above capacity");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(oldest_q) < SW'(CAPACITY))
    else $error("oldest slot out of range");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> rd_cnt_q <= fill_q)
    else $error("scan ran past stored entries");

  a_hit_keeps_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> $stable(fill_q) && $stable(oldest_q))
    else $error("duplicate changed the ring");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !out_load)
    else $error("result overwritten before taken");

endmodule

// ===== hw/rtl/tick_dedup_fifo_cache_top.sv =====
// top level of the tick duplicate filter: config register, front and back
// the back end takes the next tick from the front queue only once it is done with the last one
// the ring scan reads one stored entry per cycle
// the ring ram has one read port; a hit ends the scan at the matching entry
// reset: asynchronous active low; ring empty, counters zero, entry_limit 64
// ring contents are not cleared; only entries counted as stored are read

module tick_dedup_fifo_cache_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdfc_tick_if.sink   tick_i,
  tdfc_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tdfc_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               q_valid, q_ready;
  fp_t                q_data;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  tdfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  tdfc_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_limit_i (limit_q),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_data_i      (q_data),
    .res_o         (res_o)
  );

endmodule

// ===== dv/tdfc_tb_pkg.sv =====
// testbench types and constants for the tick duplicate filter
// depends on nothing; used by the checker and the testbench top

package tdfc_tb_pkg;

  localparam int unsigned RING_DEPTH      = 64;
  localparam logic [2:0]  REG_ENTRY_LIMIT = 3'd0;

  typedef struct packed {
    logic [63:0] symbol;
    logic [62:0] time_ns;
    logic [63:0] price;
    logic [63:0] volume;
  } tick_t;

  typedef struct packed {
    logic        dup;
    logic [63:0] processed;
    logic [63:0] dups;
    logic [6:0]  occupancy;
  } tally_t;

endpackage

// ===== dv/tdfc_checker.sv =====
// checker for the tick duplicate filter: mirrors the fingerprint ring and
// compares every result item; depends on tdfc_pkg, tdfc_tb_pkg and tdfc_if

module tdfc_checker
  import tdfc_pkg::*;
  import tdfc_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tdfc_tick_if        tick,
  tdfc_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  fp_t         ring [RING_DEPTH];
  logic [5:0]  head;
  logic [6:0]  fill;
  logic [6:0]  limit;
  logic [63:0] seen;
  logic [63:0] dups;
  tally_t      due_results [$];
  int unsigned fail_count = 0;

  assign mismatches = fail_count;

  task automatic classify_tick(input tick_t t);
    fp_t        fp;
    logic       hit;
    logic [6:0] cap;
    tally_t     r;
    fp.symbol      = t.symbol;
    fp.time_ns     = t.time_ns;
    fp.price_fold  = t.price[31:0] ^ t.price[63:32];
    fp.volume_fold = t.volume[31:0] ^ t.volume[63:32];
    cap = (limit < 7'(RING_DEPTH)) ? limit : 7'(RING_DEPTH);
    hit = 1'b0;
    for (int i = 0; i < fill; i++) begin
      if (ring[6'(head + i)] == fp) hit = 1'b1;
    end
    seen = seen + 64'd1;
    if (hit) begin
      dups = dups + 64'd1;
    end else begin
      if (fill >= 7'(RING_DEPTH)) begin
        head = head + 6'd1;
        fill = fill - 7'd1;
      end
      ring[6'(head + fill)] = fp;
      fill = fill + 7'd1;
      while (fill > cap) begin
        head = head + 6'd1;
        fill = fill - 7'd1;
      end
    end
    r.dup       = hit;
    r.processed = seen;
    r.dups      = dups;
    r.occupancy = fill;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic check_result();
    tally_t want;
    if (due_results.size() == 0) begin
      $error("result item with no tick waiting");
      fail_count++;
    end else begin
      want = due_results.pop_front();
      if (res.was_duplicate !== want.dup) begin
        $error("was_duplicate: expected %0d, actual %0d", want.dup, res.was_duplicate);
        fail_count++;
      end
      if (res.processed_total !== want.processed) begin
        $error("processed_total: expected %0d, actual %0d", want.processed,
               res.processed_total);
        fail_count++;
      end
      if (res.duplicate_total !== want.dups) begin
        $error("duplicate_total: expected %0d, actual %0d", want.dups, res.duplicate_total);
        fail_count++;
      end
      if (res.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, res.occupancy);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head  = '0;
      fill  = '0;
      seen  = '0;
      dups  = '0;
      limit = LIMIT_RESET;
      due_results.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_ENTRY_LIMIT) begin
        limit = pwdata[6:0];
      end
      if (tick.valid && tick.ready) begin
        classify_tick({tick.tick_symbol, tick.tick_time_ns, tick.price_pattern,
                       tick.trade_volume});
      end
      if (res.valid && res.ready) check_result();
      outstanding <= due_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench top for the tick duplicate filter: clock, reset, tick stimulus,
// entry limit writes and verdict; depends on tdfc_tb_pkg, tdfc_checker and the rtl

module testbench;
  import tdfc_pkg::*;
  import tdfc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tdfc_tick_if tick_if ();
  tdfc_res_if  res_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_seq = 0;
  logic [6:0]  cur_limit;
  tick_t       recent [$];

  tick_dedup_fifo_cache_top #(.CAPACITY(RING_DEPTH)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tdfc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick        (tick_if),
    .res         (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned seen_seq;
    hold_left = 0;
    seen_seq = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tick_t fresh_tick();
    tick_t t;
    t.symbol  = ($urandom_range(3) == 0) ? rand64()
                                         : {56'h2020_2020_0000_00, 8'($urandom_range(65, 68))};
    t.time_ns = 63'(rand64());
    t.price   = rand64();
    t.volume  = ($urandom_range(1) == 0) ? 64'($urandom_range(1000)) : rand64();
    case ($urandom_range(19))
      0: t.price = '0;
      1: t.volume = '1;
      2: t.time_ns = '1;
      3: t.symbol = '0;
      4: t.price = '1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic tick_t echo_tick(input int unsigned reach);
    tick_t       t;
    logic [31:0] m;
    int unsigned span;
    int unsigned idx;
    span = (reach < recent.size()) ? reach : recent.size();
    if (span == 0) span = 1;
    t = recent[recent.size() - 1 - $urandom_range(span - 1)];
    m = $urandom;
    idx = $urandom_range(63);
    case ($urandom_range(9))
      0, 1, 2: t.price ^= {m, m};
      3: t.volume ^= {m, m};
      4: begin
        case ($urandom_range(3))
          0: t.symbol[idx] = ~t.symbol[idx];
          1: t.time_ns[idx % 63] = ~t.time_ns[idx % 63];
          2: t.price[idx] = ~t.price[idx];
          default: t.volume[idx] = ~t.volume[idx];
        endcase
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid         <= 1'b1;
    tick_if.tick_symbol   <= t.symbol;
    tick_if.tick_time_ns  <= t.time_ns;
    tick_if.price_pattern <= t.price;
    tick_if.trade_volume  <= t.volume;
    do @(posedge clk_i); while (!tick_if.ready);
    recent.insert(recent.size(), t);
    if (recent.size() > 96) void'(recent.pop_front());
  endtask

  task automatic drain();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limit(input logic [31:0] data);
    drain();
    write_reg(REG_ENTRY_LIMIT, data);
    cur_limit = data[6:0];
  endtask

  task automatic run_phase(input logic [31:0] limit_word, input int unsigned count,
                           input int unsigned mode);
    set_limit(limit_word);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 45; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 45; end
      default: begin idle_pct = 36; stall_pct <= 36; end
    endcase
    if (mode == 2) hold_seq <= hold_seq + 1;
    for (int n = 0; n < count; n++) begin
      if (mode == 5 && n == count / 2) drain();
      if (recent.size() > 0 && $urandom_range(99) < 45) send_tick(echo_tick(cur_limit + 3));
      else send_tick(fresh_tick());
    end
  endtask

  initial begin
    tick_t       a;
    tick_t       b;
    logic [31:0] lim_word;
    rst_ni                = 1'b0;
    tick_if.valid         = 1'b0;
    tick_if.tick_symbol   = '0;
    tick_if.tick_time_ns  = '0;
    tick_if.price_pattern = '0;
    tick_if.trade_volume  = '0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cur_limit             = LIMIT_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, each repeated for a hit
    a = '0;
    send_tick(a);
    send_tick(a);
    a = '1;
    send_tick(a);
    send_tick(a);

    // fold collisions count as hits
    a = '{symbol: 64'h4142_4344_2020_2020, time_ns: 63'd1700000000000000000,
          price: 64'h4059_0000_0000_0000, volume: 64'd500};
    send_tick(a);
    b = a;
    b.price ^= 64'hFFFF_FFFF_FFFF_FFFF;
    send_tick(b);
    b = a;
    b.volume ^= {2{32'h1234_5678}};
    send_tick(b);

    // near misses
    b = a;
    b.time_ns = b.time_ns + 1;
    send_tick(b);
    b = a;
    b.symbol[63] = ~b.symbol[63];
    send_tick(b);
    b = a;
    b.time_ns[62] = 1'b1;
    send_tick(b);

    // limit of zero: nothing kept
    set_limit(32'd0);
    send_tick(a);
    send_tick(a);

    // limit of one
    set_limit(32'd1);
    b = fresh_tick();
    send_tick(a);
    send_tick(a);
    send_tick(b);
    send_tick(a);

    // lowered limit: a hit keeps occupancy above it, the next miss trims
    set_limit(32'd64);
    for (int n = 0; n < 8; n++) send_tick(fresh_tick());
    b = recent[recent.size() - 6];
    set_limit(32'd3);
    send_tick(b);
    send_tick(fresh_tick());

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: lim_word = 32'hFFFF_FFFF;
        1: lim_word = 32'd64;
        2: lim_word = 32'd0;
        3: lim_word = 32'd1;
        4: lim_word = 32'd2;
        5: lim_word = 32'd5;
        6: lim_word = 32'd12;
        7: lim_word = 32'd33;
        8: lim_word = 32'd63;
        default: lim_word = $urandom_range(127);
      endcase
      run_phase(lim_word, 190, p);
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tdfc_pkg.sv
hw/rtl/tdfc_if.sv
hw/rtl/tdfc_ram.sv
hw/rtl/tdfc_front.sv
hw/rtl/tdfc_back.sv
hw/rtl/tick_dedup_fifo_cache_top.sv
dv/tdfc_tb_pkg.sv
dv/tdfc_checker.sv
dv/testbench.sv
